// ===== src/dmhq_pkg.sv =====
// Package for the d-ary min-heap queue: widths, codes and shared types.
// No dependencies; used by the interface file and every module.
package dmhq_pkg;

    localparam int Capacity  = 256;
    localparam int AddrW     = 8;
    localparam int CountW    = 9;
    localparam int IdW       = 16;
    localparam int PriW      = 16;
    localparam int ArityW    = 4;
    localparam int ArityMin  = 2;
    localparam int ArityMax  = 8;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Classified command from the front part to the back part.
    typedef struct packed {
        logic            op;
        logic [IdW-1:0]  task_id;
        logic [PriW-1:0] pri;
    } t_cmd;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [PriW-1:0] pri;
    } t_slot;

endpackage

// ===== src/dmhq_if.sv =====
// Valid/ready channel interfaces for the heap queue.
// Depends on dmhq_pkg.
interface dmhq_in_if;
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [dmhq_pkg::IdW-1:0]  task_id;
    logic [dmhq_pkg::PriW-1:0] priority_req;
    modport source (output valid, op, task_id, priority_req, input ready);
    modport sink   (input valid, op, task_id, priority_req, output ready);
endinterface

interface dmhq_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [dmhq_pkg::IdW-1:0]   out_task_id;
    logic [dmhq_pkg::CountW-1:0] occupancy;
    modport source (output valid, status, out_task_id, occupancy, input ready);
    modport sink   (input valid, status, out_task_id, occupancy, output ready);
endinterface

interface dmhq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dmhq_pkg::ArityW-1:0] arity;
    modport source (output valid, arity, input ready);
    modport sink   (input valid, arity, output ready);
endinterface

// ===== src/dary_min_heap_queue.sv =====
// D-ary min-heap queue: an extract on empty or an insert on full only posts a
// status; an insert sifts the new entry up, an extract moves the last entry to
// the root and sifts it down. One item at a time in the back part: it takes
// the next command only after the previous result has left.
// Synchronous active-low reset empties the heap and sets arity to 2;
// heap memory contents are not cleared.
module dary_min_heap_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmhq_in_if.sink    in_ch,
    dmhq_out_if.source out_ch,
    dmhq_cfg_if.sink   cfg_ch
);
    logic [dmhq_pkg::ArityW-1:0] r_arity;
    logic           cmd_valid, cmd_take;
    dmhq_pkg::t_cmd cmd;

    // Hold the arity register
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arity <= 4'(dmhq_pkg::ArityMin);
        end else if (cfg_ch.valid) begin
            r_arity <= cfg_ch.arity;
        end
    end

    dmhq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    dmhq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .i_arity(r_arity),
        .o_res_valid(out_ch.valid), .i_res_ready(out_ch.ready),
        .o_status(out_ch.status), .o_task_id(out_ch.out_task_id),
        .o_occupancy(out_ch.occupancy)
    );
endmodule

// ===== src/dmhq_front.sv =====
// Front part: accept items into a two-entry command queue.
// Depends on dmhq_pkg and dmhq_if.
module dmhq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dmhq_in_if.sink           in_ch,
    output logic              o_cmd_valid,
    output dmhq_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_take
);
    dmhq_pkg::t_cmd r_q [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;
    logic           push;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // Store the item payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{op: in_ch.op, task_id: in_ch.task_id, pri: in_ch.priority_req};
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_cmd_take) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_take};
        end
    end

`ifndef SYNTHESIS
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> o_cmd_valid) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !in_ch.ready) else $error("accept while full");
`endif
endmodule

// ===== src/dmhq_back.sv =====
// Back part: heap memory and the sift sequencer, one read and one write a cycle.
// Depends on dmhq_pkg.
module dmhq_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  dmhq_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_take,
    input  logic [dmhq_pkg::ArityW-1:0]  i_arity,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [1:0]                   o_status,
    output logic [dmhq_pkg::IdW-1:0]     o_task_id,
    output logic [dmhq_pkg::CountW-1:0]  o_occupancy
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_UPRD   = 8'b00000010,
        S_UPCMP  = 8'b00000100,
        S_RROOT  = 8'b00001000,
        S_RLAST  = 8'b00010000,
        S_DNRD   = 8'b00100000,
        S_DNSCAN = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    dmhq_pkg::t_slot r_mem [dmhq_pkg::Capacity];
    dmhq_pkg::t_slot r_rdata;
    logic            mem_we;
    logic [dmhq_pkg::AddrW-1:0] mem_wa, mem_ra;
    dmhq_pkg::t_slot mem_wd;

    logic [dmhq_pkg::CountW-1:0] r_count;
    logic [dmhq_pkg::AddrW-1:0]  r_idx;      // hole being sifted
    dmhq_pkg::t_slot             r_cur;      // entry being sifted
    logic [dmhq_pkg::AddrW-1:0]  r_kid;      // next child to read
    logic [dmhq_pkg::AddrW-1:0]  r_last;     // last child of this level
    logic [dmhq_pkg::AddrW-1:0]  r_rd_addr;  // address of the read in flight
    logic                        r_first;    // read in flight is the first child
    logic [dmhq_pkg::AddrW-1:0]  r_best;
    dmhq_pkg::t_slot             r_best_v;
    logic [dmhq_pkg::ArityW-1:0] r_d;
    logic                        r_res_valid;
    logic [1:0]                  r_status;
    logic [dmhq_pkg::IdW-1:0]    r_id_out;

    // Saturate arity on use
    logic [3:0] d_eff;
    always_comb begin
        if (i_arity < 4'(dmhq_pkg::ArityMin)) d_eff = 4'(dmhq_pkg::ArityMin);
        else if (i_arity > 4'(dmhq_pkg::ArityMax)) d_eff = 4'(dmhq_pkg::ArityMax);
        else d_eff = i_arity;
    end

    // Parent index (i-1)/d by reciprocal multiply, exact for d <= 8 and i < 256
    logic [15:0]                recip;
    logic [23:0]                par_prod;
    logic [dmhq_pkg::AddrW-1:0] idx_m1, parent;
    always_comb begin
        case (r_d)
            4'd3:    recip = 16'd21846;
            4'd4:    recip = 16'd16384;
            4'd5:    recip = 16'd13108;
            4'd6:    recip = 16'd10923;
            4'd7:    recip = 16'd9363;
            4'd8:    recip = 16'd8192;
            default: recip = 16'd32768;
        endcase
        idx_m1   = r_idx - 8'd1;
        par_prod = 24'(idx_m1) * 24'(recip);
        parent   = par_prod[23:16];
    end

    // Child span i*d+1 .. i*d+d, clipped to the last entry
    logic [11:0] first_kid, last_kid, kid_end;
    assign first_kid = 12'(r_idx) * 12'(r_d) + 12'd1;
    assign last_kid  = first_kid + 12'(r_d) - 12'd1;
    assign kid_end   = (last_kid >= 12'(r_count)) ? 12'(r_count) - 12'd1 : last_kid;

    // Running minimum child; a tie keeps the lower index
    logic                       pick_new;
    dmhq_pkg::t_slot            cand_v;
    logic [dmhq_pkg::AddrW-1:0] cand_a;
    assign pick_new = r_first || (r_rdata.pri < r_best_v.pri);
    assign cand_v   = pick_new ? r_rdata : r_best_v;
    assign cand_a   = pick_new ? r_rd_addr : r_best;

    // Memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    logic take, accept_out;
    assign accept_out = r_res_valid && i_res_ready;
    assign take = (r_state == S_IDLE) && i_cmd_valid && !r_res_valid;
    assign o_cmd_take = take;

    // Sequencer next state and memory control
    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = r_cur;
        mem_ra  = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_cmd.op == dmhq_pkg::OP_INSERT) begin
                        if (r_count == 9'(dmhq_pkg::Capacity)) n_state = S_DONE;
                        else n_state = S_UPRD;
                    end else begin
                        if (r_count == '0) n_state = S_DONE;
                        else n_state = S_RROOT;
                    end
                end
            end
            S_UPRD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_idx;
                    mem_wd  = r_cur;
                    n_state = S_DONE;
                end else begin
                    mem_ra  = parent;
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                if (r_cur.pri < r_rdata.pri) begin
                    mem_wd  = r_rdata;
                    n_state = S_UPRD;
                end else begin
                    mem_wd  = r_cur;
                    n_state = S_DONE;
                end
            end
            S_RROOT: begin
                if (r_count == '0) n_state = S_DONE;
                else begin
                    mem_ra  = r_count[dmhq_pkg::AddrW-1:0];
                    n_state = S_RLAST;
                end
            end
            S_RLAST: n_state = S_DNRD;
            S_DNRD: begin
                if (first_kid < 12'(r_count)) begin
                    mem_ra  = first_kid[dmhq_pkg::AddrW-1:0];
                    n_state = S_DNSCAN;
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = r_idx;
                    mem_wd  = r_cur;
                    n_state = S_DONE;
                end
            end
            S_DNSCAN: begin
                if (r_kid <= r_last) begin
                    mem_ra = r_kid;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_idx;
                    if (cand_v.pri < r_cur.pri) begin
                        mem_wd  = cand_v;
                        n_state = S_DNRD;
                    end else begin
                        mem_wd  = r_cur;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    r_d      <= d_eff;
                    r_cur    <= '{id: i_cmd.task_id, pri: i_cmd.pri};
                    r_idx    <= r_count[dmhq_pkg::AddrW-1:0];
                    r_id_out <= '0;
                end
            end
            S_UPCMP: begin
                if (r_cur.pri < r_rdata.pri) r_idx <= parent;
            end
            S_RROOT: r_id_out <= r_rdata.id;
            S_RLAST: begin
                r_cur <= r_rdata;
                r_idx <= '0;
            end
            S_DNRD: begin
                r_rd_addr <= first_kid[dmhq_pkg::AddrW-1:0];
                r_kid     <= first_kid[dmhq_pkg::AddrW-1:0] + 8'd1;
                r_last    <= kid_end[dmhq_pkg::AddrW-1:0];
                r_first   <= 1'b1;
            end
            S_DNSCAN: begin
                r_best_v <= cand_v;
                r_best   <= cand_a;
                r_first  <= 1'b0;
                if (r_kid <= r_last) begin
                    r_rd_addr <= r_kid;
                    r_kid     <= r_kid + 8'd1;
                end else if (cand_v.pri < r_cur.pri) begin
                    r_idx <= cand_a;
                end
            end
            default: ;
        endcase
    end

    // Result register and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_res_valid <= 1'b0;
            r_status <= dmhq_pkg::ST_INSERTED;
        end else begin
            r_state <= n_state;
            if (accept_out) r_res_valid <= 1'b0;
            if (take) begin
                if (i_cmd.op == dmhq_pkg::OP_INSERT) begin
                    if (r_count == 9'(dmhq_pkg::Capacity)) r_status <= dmhq_pkg::ST_FULL;
                    else begin
                        r_status <= dmhq_pkg::ST_INSERTED;
                        r_count <= r_count + 9'd1;
                    end
                end else begin
                    if (r_count == '0) r_status <= dmhq_pkg::ST_EMPTY;
                    else begin
                        r_status <= dmhq_pkg::ST_EXTRACTED;
                        r_count <= r_count - 9'd1;
                    end
                end
            end
            if (r_state == S_DONE) r_res_valid <= 1'b1;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_status    = r_status;
    assign o_task_id   = (r_status == dmhq_pkg::ST_EXTRACTED) ? r_id_out : '0;
    assign o_occupancy = r_count;

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> (r_state != S_IDLE)) else $error("take did not start work");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 9'(dmhq_pkg::Capacity)) else $error("count over capacity");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_res_valid) else $error("result not posted");
`endif
endmodule

// ===== dv/dmhq_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench package: the result item type shared by the checker and predictor.
// The channel interfaces come from src/dmhq_if.sv; depends on dmhq_pkg.
package dmhq_tb_pkg;

    // One expected or observed result item.
    typedef struct packed {
        logic [1:0]                  status;
        logic [dmhq_pkg::IdW-1:0]    task_id;
        logic [dmhq_pkg::CountW-1:0] occupancy;
    } t_outcome;
endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for dary_min_heap_queue: directed table then random insert/extract traffic,
// checked against an in-bench d-ary heap model. Depends on dmhq_pkg, dmhq_if, dmhq_tb_pkg.
module testbench;
    logic i_clk;
    logic i_rst_n;

    dmhq_in_if  in_ch ();
    dmhq_out_if out_ch ();
    dmhq_cfg_if cfg_ch ();

    dary_min_heap_queue u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Heap shadow
    dmhq_pkg::t_slot             shadow_heap [dmhq_pkg::Capacity];
    int unsigned                 shadow_count;
    logic [dmhq_pkg::ArityW-1:0] shadow_arity;
    dmhq_tb_pkg::t_outcome       pending_results [$];
    int                          mismatch_count;
    bit                          check_enabled;
    int                          next_gap;

    // Directed rows: expected result given only where obvious
    typedef struct {
        logic                     op;
        logic [dmhq_pkg::IdW-1:0]  task_id;
        logic [dmhq_pkg::PriW-1:0] pri;
        bit                       has_fixed;
        dmhq_tb_pkg::t_outcome    fixed;
    } t_row;

    function automatic int unsigned fanout();
        if (shadow_arity < dmhq_pkg::ArityMin) return dmhq_pkg::ArityMin;
        if (shadow_arity > dmhq_pkg::ArityMax) return dmhq_pkg::ArityMax;
        return shadow_arity;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        dmhq_pkg::t_slot t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    // Apply one command to the shadow heap and return its result item
    function automatic dmhq_tb_pkg::t_outcome apply_command(logic op,
                                               logic [dmhq_pkg::IdW-1:0] id,
                                               logic [dmhq_pkg::PriW-1:0] pri);
        dmhq_tb_pkg::t_outcome r;
        int unsigned d, i, p, first, last, best;
        d = fanout();
        r = '0;
        if (op == dmhq_pkg::OP_INSERT) begin
            if (shadow_count >= dmhq_pkg::Capacity) begin
                r.status = dmhq_pkg::ST_FULL;
            end else begin
                shadow_heap[shadow_count] = '{id: id, pri: pri};
                i = shadow_count;
                shadow_count++;
                while (i > 0) begin
                    p = (i - 1) / d;
                    if (shadow_heap[i].pri < shadow_heap[p].pri) begin
                        swap_slots(i, p);
                        i = p;
                    end else break;
                end
                r.status = dmhq_pkg::ST_INSERTED;
            end
        end else if (shadow_count == 0) begin
            r.status = dmhq_pkg::ST_EMPTY;
        end else begin
            r.status = dmhq_pkg::ST_EXTRACTED;
            r.task_id = shadow_heap[0].id;
            shadow_count--;
            if (shadow_count > 0) begin
                shadow_heap[0] = shadow_heap[shadow_count];
                i = 0;
                while (1) begin
                    first = i * d + 1;
                    if (first >= shadow_count) break;
                    last = first + d - 1;
                    if (last >= shadow_count) last = shadow_count - 1;
                    best = first;
                    for (int unsigned k = first + 1; k <= last; k++)
                        if (shadow_heap[k].pri < shadow_heap[best].pri) best = k;
                    if (shadow_heap[best].pri < shadow_heap[i].pri) begin
                        swap_slots(i, best);
                        i = best;
                    end else break;
                end
            end
        end
        r.occupancy = shadow_count[dmhq_pkg::CountW-1:0];
        return r;
    endfunction

    // Send one item after its drawn gap, queue its expected result
    task automatic send_item(logic op, logic [dmhq_pkg::IdW-1:0] id,
                             logic [dmhq_pkg::PriW-1:0] pri,
                             bit has_fixed, dmhq_tb_pkg::t_outcome fixed);
        dmhq_tb_pkg::t_outcome predicted;
        repeat (next_gap) @(posedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.task_id      <= id;
        in_ch.priority_req <= pri;
        predicted = apply_command(op, id, pri);
        if (has_fixed && predicted != fixed)
            $display("directed row disagrees with heap shadow: %h vs %h", fixed, predicted);
        pending_results.push_back(has_fixed ? fixed : predicted);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // Draw the gap before the next item; hold valid only when it follows at once
        next_gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) next_gap = 0;
        if (next_gap != 0) in_ch.valid <= 1'b0;
    endtask

    // Drop valid when no further item follows right away
    task automatic release_input();
        if (next_gap == 0) in_ch.valid <= 1'b0;
    endtask

    // Write the arity register while idle
    task automatic write_arity(logic [dmhq_pkg::ArityW-1:0] value);
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.arity <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        shadow_arity = value;
    endtask

    // Result checker: compare against the oldest expectation
    always @(posedge i_clk) begin
        dmhq_tb_pkg::t_outcome got, want;
        if (check_enabled && out_ch.valid && out_ch.ready) begin
            got = '{status: out_ch.status, task_id: out_ch.out_task_id,
                    occupancy: out_ch.occupancy};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item: %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: status exp %0d got %0d, id exp %h got %h,",
                                  " occ exp %0d got %0d"},
                                 want.status, got.status, want.task_id, got.task_id,
                                 want.occupancy, got.occupancy);
                end
            end
        end
    end

    // Result sink: after each accepted item, draw a random wait before ready rises again
    int stall_left;
    always @(posedge i_clk) begin
        int wait_cycles;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (out_ch.ready && out_ch.valid) begin
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles != 0) begin
                out_ch.ready <= 1'b0;
                stall_left   <= wait_cycles - 1;
            end
        end else if (!out_ch.ready) begin
            if (stall_left > 0) stall_left <= stall_left - 1;
            else out_ch.ready <= 1'b1;
        end
    end

    initial begin
        t_row                        rows [$];
        dmhq_tb_pkg::t_outcome       none;
        logic [dmhq_pkg::ArityW-1:0] arity_plan [6];
        none = '0;
        arity_plan = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd1, 4'd5};
        in_ch.valid = 1'b0;
        in_ch.op = dmhq_pkg::OP_INSERT;
        in_ch.task_id = '0;
        in_ch.priority_req = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.arity = '0;
        i_rst_n = 1'b0;
        mismatch_count = 0;
        check_enabled = 1'b0;
        shadow_count = 0;
        shadow_arity = dmhq_pkg::ArityMin;
        next_gap = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_enabled = 1'b1;

        // Directed: empty extract, extremes, ties, ignored fields on extract
        rows.push_back('{dmhq_pkg::OP_EXTRACT, 16'hFFFF, 16'hFFFF, 1'b1,
                         '{dmhq_pkg::ST_EMPTY, 16'h0, 9'd0}});
        rows.push_back('{dmhq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b1,
                         '{dmhq_pkg::ST_INSERTED, 16'h0, 9'd1}});
        rows.push_back('{dmhq_pkg::OP_INSERT, 16'h0000, 16'h0000, 1'b1,
                         '{dmhq_pkg::ST_INSERTED, 16'h0, 9'd2}});
        rows.push_back('{dmhq_pkg::OP_INSERT, 16'hAAAA, 16'h0000, 1'b1,
                         '{dmhq_pkg::ST_INSERTED, 16'h0, 9'd3}});
        rows.push_back('{dmhq_pkg::OP_INSERT, 16'h5555, 16'h8000, 1'b0, none});
        rows.push_back('{dmhq_pkg::OP_INSERT, 16'h1234, 16'h0001, 1'b0, none});
        rows.push_back('{dmhq_pkg::OP_EXTRACT, 16'h5555, 16'hAAAA, 1'b1,
                         '{dmhq_pkg::ST_EXTRACTED, 16'h0, 9'd4}});
        rows.push_back('{dmhq_pkg::OP_EXTRACT, 16'h0, 16'h0, 1'b0, none});
        rows.push_back('{dmhq_pkg::OP_EXTRACT, 16'h0, 16'h0, 1'b0, none});
        rows.push_back('{dmhq_pkg::OP_EXTRACT, 16'h0, 16'h0, 1'b0, none});
        rows.push_back('{dmhq_pkg::OP_EXTRACT, 16'h0, 16'h0, 1'b1,
                         '{dmhq_pkg::ST_EXTRACTED, 16'hFFFF, 9'd0}});
        rows.push_back('{dmhq_pkg::OP_EXTRACT, 16'h0, 16'h0, 1'b1,
                         '{dmhq_pkg::ST_EMPTY, 16'h0, 9'd0}});
        foreach (rows[n])
            send_item(rows[n].op, rows[n].task_id, rows[n].pri, rows[n].has_fixed,
                      rows[n].fixed);

        // Fill past capacity at the default arity
        for (int n = 0; n < dmhq_pkg::Capacity + 2; n++)
            send_item(dmhq_pkg::OP_INSERT, 16'($urandom), 16'($urandom_range(0, 15)),
                      1'b0, none);

        // Mostly extracts across arity settings, extremes and out-of-range values
        foreach (arity_plan[p]) begin
            write_arity(arity_plan[p]);
            for (int n = 0; n < 30; n++) begin
                send_item(($urandom_range(0, 4) == 0) ? dmhq_pkg::OP_INSERT
                                                       : dmhq_pkg::OP_EXTRACT,
                          16'($urandom),
                          ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7))),
                          1'b0, none);
            end
        end

        // Drain past empty at the widest arity
        write_arity(4'd8);
        while (shadow_count > 0)
            send_item(dmhq_pkg::OP_EXTRACT, 16'($urandom), 16'($urandom), 1'b0, none);
        repeat (2) send_item(dmhq_pkg::OP_EXTRACT, 16'($urandom), 16'($urandom), 1'b0, none);

        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
src/dmhq_pkg.sv
src/dmhq_if.sv
src/dmhq_front.sv
src/dmhq_back.sv
src/dary_min_heap_queue.sv
dv/dmhq_tb_if.sv
dv/testbench.sv
